@@ design/l2cap_channel_setup_fsm_core_defines.svh @@
// Assertion helpers shared by the channel setup RTL.
// Each helper samples on clk and stays quiet while rst_n is low.
`ifndef L2CAP_CHANNEL_SETUP_FSM_CORE_DEFINES_SVH
`define L2CAP_CHANNEL_SETUP_FSM_CORE_DEFINES_SVH

// Same-cycle implication
`define LCSF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcsf same-cycle check failed");

// Next-cycle implication
`define LCSF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcsf next-cycle check failed");

`endif

@@ design/lcsf_pkg.sv @@
package lcsf_pkg;

  // Event opcodes (code 7 is unused)
  typedef enum logic [2:0] {
    OP_OPEN         = 3'd0,
    OP_LOCAL_DISC   = 3'd1,
    OP_INBOUND_CONN = 3'd2,
    OP_CONN_RSP     = 3'd3,
    OP_CFG_REQ      = 3'd4,
    OP_CFG_RSP      = 3'd5,
    OP_DISC_REQ     = 3'd6
  } opcode_t;

  // Signaling message to send
  typedef enum logic [2:0] {
    MSG_NONE       = 3'd0,
    MSG_CONN_REQ   = 3'd1,
    MSG_CONN_RSP   = 3'd2,
    MSG_CFG_REQ    = 3'd3,
    MSG_CFG_RSP    = 3'd4,
    MSG_DISC_RSP   = 3'd5,
    MSG_DISC_REQ   = 3'd6
  } msg_kind_t;

  // Open result event
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_OPENED = 2'd1,
    EV_FAILED = 2'd2
  } open_ev_t;

  // Progress flag bit positions
  localparam int unsigned F_CONN_REQ  = 0;
  localparam int unsigned F_CONN_RSP  = 1;
  localparam int unsigned F_LCFG_SENT = 2;
  localparam int unsigned F_LCFG_OK   = 3;
  localparam int unsigned F_RCFG_RECV = 4;
  localparam int unsigned F_RCFG_OK   = 5;
  localparam int unsigned F_DISC      = 6;
  localparam int unsigned NUM_FLAGS   = 7;

  // Peer result codes and id range
  localparam logic [15:0] CONN_RES_SUCCESS = 16'h0000;
  localparam logic [15:0] CONN_RES_PENDING = 16'h0001;
  localparam logic [15:0] CFG_RES_SUCCESS  = 16'h0000;
  localparam logic [15:0] CFG_RES_PENDING  = 16'h0004;
  localparam logic [15:0] INVALID_CID      = 16'h0000;
  localparam logic [15:0] FIRST_DYNAMIC_ID = 16'h0040;

  // Configuration registers
  localparam logic        REG_OWN_CID         = 1'b0;
  localparam logic        REG_SERVICE_PSM     = 1'b1;
  localparam logic [15:0] OWN_CID_RESET       = 16'h0040;
  localparam logic [15:0] SERVICE_PSM_RESET   = 16'h0001;

  typedef struct packed {
    logic [15:0] own_cid;
    logic [15:0] service_psm;
  } cfg_t;

  typedef struct packed {
    opcode_t     opcode;
    logic        cmd_rejected;
    logic [15:0] resp_local_cid;
    logic [15:0] peer_cid;
    logic [15:0] resp_result;
  } item_t;

  typedef struct packed {
    msg_kind_t   msg_kind;
    logic [15:0] msg_dest_cid;
    logic [15:0] msg_source_cid;
    logic [15:0] msg_service;
    open_ev_t    open_event;
    logic        closed_notice;
    logic        channel_open;
    logic        last_of_run;
  } res_t;

  // Push request into the result buffer
  typedef struct packed {
    logic valid;
    logic two;
  } push_t;

  // Free space seen by the event stage
  typedef struct packed {
    logic one;
    logic two;
  } room_t;

endpackage

@@ design/lcsf_cfg_regs.sv @@
module lcsf_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output lcsf_pkg::cfg_t    cfg
);
  import lcsf_pkg::*;

  logic [15:0] own_cid_r;
  logic [15:0] service_psm_r;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[2];

  // Write on the access beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_cid_r     <= OWN_CID_RESET;
      service_psm_r <= SERVICE_PSM_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_OWN_CID:     own_cid_r     <= pwdata[15:0];
        REG_SERVICE_PSM: service_psm_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_OWN_CID:     prdata = {16'h0000, own_cid_r};
      REG_SERVICE_PSM: prdata = {16'h0000, service_psm_r};
      default:         prdata = 32'h0000_0000;
    endcase
  end

  assign cfg.own_cid     = own_cid_r;
  assign cfg.service_psm = service_psm_r;

endmodule

@@ design/lcsf_ctrl.sv @@
`include "l2cap_channel_setup_fsm_core_defines.svh"

module lcsf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            go,
  input  lcsf_pkg::item_t item,
  input  lcsf_pkg::cfg_t  cfg,
  output lcsf_pkg::res_t  res_first,
  output lcsf_pkg::res_t  res_final,
  output logic            two
);
  import lcsf_pkg::*;

  logic [NUM_FLAGS-1:0] flags_r, flags_nxt;
  logic [15:0]          remote_r, remote_nxt;
  logic                 owed_r, owed_nxt;
  logic                 opened_r, opened_nxt;

  msg_kind_t   kind;
  logic [15:0] dst;
  logic [15:0] src;
  logic [15:0] svc;
  open_ev_t    ev;
  logic        closed;
  logic        open_now;
  logic        conn_now;

  function automatic logic connected_f(logic [NUM_FLAGS-1:0] f, logic [15:0] rid);
    connected_f = f[F_CONN_REQ] & f[F_CONN_RSP] & (rid != INVALID_CID) & ~f[F_DISC];
  endfunction

  function automatic logic open_f(logic [NUM_FLAGS-1:0] f, logic [15:0] rid);
    open_f = connected_f(f, rid) & f[F_LCFG_OK] & f[F_RCFG_OK];
  endfunction

  assign two      = (item.opcode == OP_INBOUND_CONN);
  assign conn_now = connected_f(flags_r, remote_r);

  // Evaluate one event against the current state
  always_comb begin
    flags_nxt  = flags_r;
    remote_nxt = remote_r;
    owed_nxt   = owed_r;
    opened_nxt = opened_r;
    kind       = MSG_NONE;
    dst        = 16'h0000;
    src        = 16'h0000;
    svc        = 16'h0000;
    ev         = EV_NONE;
    closed     = 1'b0;
    case (item.opcode)
      OP_OPEN: begin
        owed_nxt = 1'b1;
        if (!flags_r[F_CONN_REQ]) begin
          kind                  = MSG_CONN_REQ;
          src                   = cfg.own_cid;
          svc                   = cfg.service_psm;
          flags_nxt[F_CONN_REQ] = 1'b1;
        end
      end
      OP_LOCAL_DISC: begin
        if (!flags_r[F_DISC]) begin
          flags_nxt[F_DISC] = 1'b1;
          if (remote_r != INVALID_CID) begin
            kind = MSG_DISC_REQ;
            dst  = remote_r;
            src  = cfg.own_cid;
          end
        end
      end
      OP_INBOUND_CONN: begin
        // Restart: connected, local config request goes out right away
        flags_nxt              = '0;
        flags_nxt[F_CONN_REQ]  = 1'b1;
        flags_nxt[F_CONN_RSP]  = 1'b1;
        flags_nxt[F_LCFG_SENT] = 1'b1;
        remote_nxt             = item.peer_cid;
        owed_nxt               = 1'b0;
        opened_nxt             = 1'b0;
        kind                   = MSG_CFG_REQ;
        dst                    = item.peer_cid;
      end
      OP_CONN_RSP: begin
        if (item.cmd_rejected || (item.resp_local_cid != cfg.own_cid) ||
            flags_r[F_CONN_RSP] || !flags_r[F_CONN_REQ]) begin
          ev       = owed_r ? EV_FAILED : EV_NONE;
          owed_nxt = 1'b0;
        end else if (item.resp_result == CONN_RES_PENDING) begin
          if (item.peer_cid != INVALID_CID) remote_nxt = item.peer_cid;
        end else if ((item.resp_result != CONN_RES_SUCCESS) ||
                     (item.peer_cid < FIRST_DYNAMIC_ID)) begin
          ev       = owed_r ? EV_FAILED : EV_NONE;
          owed_nxt = 1'b0;
        end else begin
          flags_nxt[F_CONN_RSP] = 1'b1;
          remote_nxt            = item.peer_cid;
          if (!flags_r[F_LCFG_SENT]) begin
            flags_nxt[F_LCFG_SENT] = 1'b1;
            kind                   = MSG_CFG_REQ;
            dst                    = item.peer_cid;
          end
        end
      end
      OP_CFG_REQ: begin
        if ((item.resp_local_cid == cfg.own_cid) && conn_now) begin
          flags_nxt[F_RCFG_RECV] = 1'b1;
          flags_nxt[F_RCFG_OK]   = 1'b1;
          kind                   = MSG_CFG_RSP;
          src                    = remote_r;
          if (flags_r[F_LCFG_OK]) begin
            opened_nxt = 1'b1;
            ev         = owed_r ? EV_OPENED : EV_NONE;
            owed_nxt   = 1'b0;
          end
        end
      end
      OP_CFG_RSP: begin
        if (item.cmd_rejected) begin
          ev       = owed_r ? EV_FAILED : EV_NONE;
          owed_nxt = 1'b0;
        end else if (item.resp_result == CFG_RES_PENDING) begin
          // peer still pending: hold
        end else if ((item.resp_result != CFG_RES_SUCCESS) ||
                     (item.resp_local_cid != cfg.own_cid)) begin
          ev       = owed_r ? EV_FAILED : EV_NONE;
          owed_nxt = 1'b0;
        end else begin
          flags_nxt[F_LCFG_OK] = 1'b1;
          if (conn_now && flags_r[F_RCFG_OK]) begin
            opened_nxt = 1'b1;
            ev         = owed_r ? EV_OPENED : EV_NONE;
            owed_nxt   = 1'b0;
          end
        end
      end
      OP_DISC_REQ: begin
        if ((item.resp_local_cid == cfg.own_cid) && (item.peer_cid == remote_r)) begin
          flags_nxt[F_DISC] = 1'b1;
          kind              = MSG_DISC_RSP;
          dst               = cfg.own_cid;
          src               = remote_r;
          closed            = opened_r;
        end
      end
      default: ;
    endcase
    open_now = open_f(flags_nxt, remote_nxt);
  end

  // Assemble results
  always_comb begin
    res_first.msg_kind       = MSG_CONN_RSP;
    res_first.msg_dest_cid   = item.peer_cid;
    res_first.msg_source_cid = cfg.own_cid;
    res_first.msg_service    = 16'h0000;
    res_first.open_event     = EV_NONE;
    res_first.closed_notice  = 1'b0;
    res_first.channel_open   = open_now;
    res_first.last_of_run    = 1'b0;

    res_final.msg_kind       = kind;
    res_final.msg_dest_cid   = dst;
    res_final.msg_source_cid = src;
    res_final.msg_service    = svc;
    res_final.open_event     = ev;
    res_final.closed_notice  = closed;
    res_final.channel_open   = open_now;
    res_final.last_of_run    = 1'b1;
  end

  // Commit state when the event moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r  <= '0;
      remote_r <= INVALID_CID;
      owed_r   <= 1'b0;
      opened_r <= 1'b0;
    end else if (go) begin
      flags_r  <= flags_nxt;
      remote_r <= remote_nxt;
      owed_r   <= owed_nxt;
      opened_r <= opened_nxt;
    end
  end

  `LCSF_ASSERT_NXT(a_conn_takes_peer, go && (item.opcode == OP_INBOUND_CONN), remote_r == $past(item.peer_cid))
  `LCSF_ASSERT_NXT(a_report_clears_owed, go && (res_final.open_event != EV_NONE), !owed_r)
  `LCSF_ASSERT_IMP(a_open_on_cfg, $rose(opened_r), $past(go) && (($past(item.opcode) == OP_CFG_REQ) || ($past(item.opcode) == OP_CFG_RSP)))

endmodule

@@ design/lcsf_obuf.sv @@
`include "l2cap_channel_setup_fsm_core_defines.svh"

module lcsf_obuf (
  input  logic            clk,
  input  logic            rst_n,
  input  lcsf_pkg::push_t push,
  input  lcsf_pkg::res_t  res_first,
  input  lcsf_pkg::res_t  res_final,
  output lcsf_pkg::room_t room,
  output logic            out_valid,
  input  logic            out_ready,
  output lcsf_pkg::res_t  out_res
);
  import lcsf_pkg::*;

  res_t       e0_r, e0_nxt;
  res_t       e1_r, e1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] cnt_left;
  logic       pop;

  // Room is taken from registered count only
  assign room.one  = (cnt_r != 2'd2);
  assign room.two  = (cnt_r == 2'd0);
  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = e0_r;
  assign pop       = out_valid & out_ready;

  // Drop the head on a beat, then append new results
  always_comb begin
    e0_nxt   = e0_r;
    e1_nxt   = e1_r;
    cnt_left = cnt_r;
    if (pop) begin
      e0_nxt   = e1_r;
      cnt_left = cnt_r - 2'd1;
    end
    cnt_nxt = cnt_left;
    if (push.valid) begin
      if (push.two) begin
        e0_nxt  = res_first;
        e1_nxt  = res_final;
        cnt_nxt = 2'd2;
      end else if (cnt_left == 2'd0) begin
        e0_nxt  = res_final;
        cnt_nxt = 2'd1;
      end else begin
        e1_nxt  = res_final;
        cnt_nxt = 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `LCSF_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r != 2'd3)
  `LCSF_ASSERT_IMP(a_nonlast_has_tail, (cnt_r != 2'd0) && !e0_r.last_of_run, cnt_r == 2'd2)
  `LCSF_ASSERT_IMP(a_pair_needs_empty, push.valid && push.two, cnt_r == 2'd0)

endmodule

@@ design/l2cap_channel_setup_fsm_core.sv @@
// Channel   Dir  Beat contents
// in_*      in   one event: opcode in tuser, operands in tdata
// out_*     out  one result: message kind in tuser, ids/events in tdata, tlast ends event
// cfg_*     in   register write/read: own_cid at 0x0, service_psm at 0x4
//
// An event beat lands in the input register, is evaluated against the state
// registers and its results enter a two-entry result buffer, from whose head
// register they leave; single-result events sustain one per cycle while
// out_tready stays high. Inbound connect waits for an empty result buffer
// before both of its results enter it.
// Reset (rst_n low, synchronous) clears progress state and both buffers.
// Input stalls only while the result buffer lacks room for the held event.
module l2cap_channel_setup_fsm_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] cmd_rejected, [16:1] resp_local_cid, [32:17] peer_cid,
  // [48:33] resp_result, [55:49] zero
  input  logic [55:0] in_tdata,
  // [2:0] opcode
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] msg_dest_cid, [31:16] msg_source_cid, [47:32] msg_service,
  // [49:48] open_event, [50] closed_notice, [51] channel_open, [55:52] zero
  output logic [55:0] out_tdata,
  // [2:0] msg_kind
  output logic [2:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lcsf_pkg::*;

  cfg_t  cfg;
  item_t item_r;
  logic  item_v_r;
  logic  go;
  logic  two;
  res_t  res_first;
  res_t  res_final;
  res_t  out_res;
  room_t room;
  push_t push;

  lcsf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Move the held event on when its results fit
  assign go        = item_v_r & (two ? room.two : room.one);
  assign in_tready = ~item_v_r | go;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_tready) begin
      item_v_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      item_r.opcode         <= opcode_t'(in_tuser);
      item_r.cmd_rejected   <= in_tdata[0];
      item_r.resp_local_cid <= in_tdata[16:1];
      item_r.peer_cid       <= in_tdata[32:17];
      item_r.resp_result    <= in_tdata[48:33];
    end
  end

  lcsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .item      (item_r),
    .cfg       (cfg),
    .res_first (res_first),
    .res_final (res_final),
    .two       (two)
  );

  assign push.valid = go;
  assign push.two   = two;

  lcsf_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res_first (res_first),
    .res_final (res_final),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // Pack the result beat
  assign out_tuser = out_res.msg_kind;
  assign out_tlast = out_res.last_of_run;
  assign out_tdata = {4'h0, out_res.channel_open, out_res.closed_notice, out_res.open_event,
                      out_res.msg_service, out_res.msg_source_cid, out_res.msg_dest_cid};

endmodule

@@ tb/tb_l2cap_channel_setup_fsm_core.sv @@
`timescale 1ns / 100ps

import lcsf_pkg::*;

// Tracks the channel's progress flags and predicts the result beats of each event
class channel_setup_model;
  logic [15:0]          own_cid;
  logic [15:0]          service_psm;
  logic [NUM_FLAGS-1:0] flags;
  logic [15:0]          remote_id;
  logic                 owed;
  logic                 opened;
  res_t                 pending_results[$];
  int unsigned          fails;

  function new();
    own_cid     = OWN_CID_RESET;
    service_psm = SERVICE_PSM_RESET;
    flags       = '0;
    remote_id   = INVALID_CID;
    owed        = 1'b0;
    opened      = 1'b0;
    fails       = 0;
  endfunction

  function void set_register(logic idx, logic [15:0] value);
    if (idx == REG_OWN_CID) begin
      own_cid = value;
    end else begin
      service_psm = value;
    end
  endfunction

  function bit chan_connected();
    return flags[F_CONN_REQ] && flags[F_CONN_RSP] && remote_id != INVALID_CID &&
           !flags[F_DISC];
  endfunction

  function bit chan_open();
    return chan_connected() && flags[F_LCFG_OK] && flags[F_RCFG_OK];
  endfunction

  // Report an open outcome only while the local open still waits for one
  function open_ev_t take_report(open_ev_t ev);
    if (owed) begin
      owed = 1'b0;
      return ev;
    end
    return EV_NONE;
  endfunction

  // Send the local configuration request only once per connection
  function bit start_local_cfg();
    if (flags[F_LCFG_SENT]) return 1'b0;
    flags[F_LCFG_SENT] = 1'b1;
    return 1'b1;
  endfunction

  function void note_event(item_t it);
    res_t r;
    res_t first;
    bit   two;
    r     = '0;
    first = '0;
    two   = 1'b0;
    case (it.opcode)
      OP_OPEN: begin
        owed = 1'b1;
        if (!flags[F_CONN_REQ]) begin
          r.msg_kind       = MSG_CONN_REQ;
          r.msg_source_cid = own_cid;
          r.msg_service    = service_psm;
          flags[F_CONN_REQ] = 1'b1;
        end
      end
      OP_LOCAL_DISC: begin
        if (!flags[F_DISC]) begin
          flags[F_DISC] = 1'b1;
          if (remote_id != INVALID_CID) begin
            r.msg_kind       = MSG_DISC_REQ;
            r.msg_dest_cid   = remote_id;
            r.msg_source_cid = own_cid;
          end
        end
      end
      OP_INBOUND_CONN: begin
        // restart the channel, answer the peer and send our config
        flags              = '0;
        flags[F_CONN_REQ]  = 1'b1;
        flags[F_CONN_RSP]  = 1'b1;
        remote_id          = it.peer_cid;
        owed               = 1'b0;
        opened             = 1'b0;
        two                = 1'b1;
        first.msg_kind       = MSG_CONN_RSP;
        first.msg_dest_cid   = remote_id;
        first.msg_source_cid = own_cid;
        if (start_local_cfg()) begin
          r.msg_kind     = MSG_CFG_REQ;
          r.msg_dest_cid = remote_id;
        end
      end
      OP_CONN_RSP: begin
        if (it.cmd_rejected || it.resp_local_cid != own_cid || flags[F_CONN_RSP] ||
            !flags[F_CONN_REQ]) begin
          r.open_event = take_report(EV_FAILED);
        end else if (it.resp_result == CONN_RES_PENDING) begin
          if (it.peer_cid != INVALID_CID) remote_id = it.peer_cid;
        end else if (it.resp_result != CONN_RES_SUCCESS ||
                     it.peer_cid < FIRST_DYNAMIC_ID) begin
          r.open_event = take_report(EV_FAILED);
        end else begin
          flags[F_CONN_RSP] = 1'b1;
          remote_id         = it.peer_cid;
          if (start_local_cfg()) begin
            r.msg_kind     = MSG_CFG_REQ;
            r.msg_dest_cid = remote_id;
          end
        end
      end
      OP_CFG_REQ: begin
        if (it.resp_local_cid == own_cid && chan_connected()) begin
          flags[F_RCFG_RECV] = 1'b1;
          flags[F_RCFG_OK]   = 1'b1;
          r.msg_kind         = MSG_CFG_RSP;
          r.msg_source_cid   = remote_id;
          if (chan_open()) begin
            opened       = 1'b1;
            r.open_event = take_report(EV_OPENED);
          end
        end
      end
      OP_CFG_RSP: begin
        if (it.cmd_rejected) begin
          r.open_event = take_report(EV_FAILED);
        end else if (it.resp_result == CFG_RES_PENDING) begin
          // peer still working on it: nothing changes
        end else if (it.resp_result != CFG_RES_SUCCESS || it.resp_local_cid != own_cid) begin
          r.open_event = take_report(EV_FAILED);
        end else begin
          flags[F_LCFG_OK] = 1'b1;
          if (chan_open()) begin
            opened       = 1'b1;
            r.open_event = take_report(EV_OPENED);
          end
        end
      end
      OP_DISC_REQ: begin
        if (it.resp_local_cid == own_cid && it.peer_cid == remote_id) begin
          flags[F_DISC]    = 1'b1;
          r.msg_kind       = MSG_DISC_RSP;
          r.msg_dest_cid   = own_cid;
          r.msg_source_cid = remote_id;
          r.closed_notice  = opened;
        end
      end
      default: begin
        // unused code: a bare result, no state change
      end
    endcase
    r.channel_open = chan_open();
    r.last_of_run  = 1'b1;
    if (two) begin
      first.channel_open = chan_open();
      first.last_of_run  = 1'b0;
      pending_results.push_back(first);
    end
    pending_results.push_back(r);
  endfunction

  function void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  function void check_result(res_t got);
    res_t want;
    if (pending_results.size() == 0) begin
      $error("result beat with nothing pending: msg_kind %0d", got.msg_kind);
      fails++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("msg_kind", 16'(want.msg_kind), 16'(got.msg_kind));
    compare_field("msg_dest_cid", want.msg_dest_cid, got.msg_dest_cid);
    compare_field("msg_source_cid", want.msg_source_cid, got.msg_source_cid);
    compare_field("msg_service", want.msg_service, got.msg_service);
    compare_field("open_event", 16'(want.open_event), 16'(got.open_event));
    compare_field("closed_notice", 16'(want.closed_notice), 16'(got.closed_notice));
    compare_field("channel_open", 16'(want.channel_open), 16'(got.channel_open));
    compare_field("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
  endfunction
endclass

module tb_l2cap_channel_setup_fsm_core;
  localparam int QUIET_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int PAUSE_EVERY     = 80;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // [0] cmd_rejected, [16:1] resp_local_cid, [32:17] peer_cid,
  // [48:33] resp_result, [55:49] zero
  logic [55:0] in_tdata;
  // [2:0] opcode
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  // [15:0] msg_dest_cid, [31:16] msg_source_cid, [47:32] msg_service,
  // [49:48] open_event, [50] closed_notice, [51] channel_open, [55:52] zero
  logic [55:0] out_tdata;
  // [2:0] msg_kind
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  channel_setup_model sb;
  int          src_idle_pct;
  int          stall_pct;
  int          items_sent;
  int          quiet_cycles;
  logic [15:0] cur_own;
  logic [15:0] sess_peer;

  l2cap_channel_setup_fsm_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= stall_pct);
  end

  // Check result beats and watch for a hang
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_tvalid && out_tready) begin
        sb.check_result(res_t'({out_tuser, out_tdata[15:0], out_tdata[31:16],
                                out_tdata[47:32], out_tdata[49:48], out_tdata[50],
                                out_tdata[51], out_tlast}));
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Drive one event beat; entered and left at a falling edge
  task automatic send_event(opcode_t op, logic rej, logic [15:0] lcid, logic [15:0] pcid,
                            logic [15:0] res);
    item_t it;
    it.opcode         = op;
    it.cmd_rejected   = rej;
    it.resp_local_cid = lcid;
    it.peer_cid       = pcid;
    it.resp_result    = res;
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, res, pcid, lcid, rej};
    in_tuser  <= op;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_event(it);
    items_sent++;
    @(negedge clk);
  endtask

  // Hold the sender until every pending result has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write a register, then read it back
  task automatic program_reg(logic idx, logic [15:0] value);
    logic [31:0] rd;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'h0000, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    sb.set_register(idx, value);
    if (idx == REG_OWN_CID) cur_own = value;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd[15:0] !== value) begin
      $error("%s readback mismatch: expected 0x%0h, got 0x%0h",
             (idx == REG_OWN_CID) ? "own_cid" : "service_psm", value, rd[15:0]);
      sb.fails++;
    end
  endtask

  task automatic send_noise();
    opcode_t     op;
    logic [15:0] lcid;
    logic [15:0] pcid;
    logic [15:0] res;
    op   = opcode_t'($urandom_range(7, 0));
    lcid = $urandom_range(1, 0) ? cur_own : 16'($urandom_range(65535, 0));
    pcid = ($urandom_range(3, 0) == 0) ? sess_peer : 16'($urandom_range(65535, 0));
    case ($urandom_range(3, 0))
      0:       res = CONN_RES_SUCCESS;
      1:       res = CONN_RES_PENDING;
      2:       res = CFG_RES_PENDING;
      default: res = 16'($urandom_range(65535, 0));
    endcase
    send_event(op, 1'($urandom_range(1, 0)), lcid, pcid, res);
  endtask

  task automatic maybe_noise();
    if ($urandom_range(99, 0) < 15) send_noise();
  endtask

  // One inbound channel setup and teardown, with random content and damage
  task automatic run_session();
    int close_pick;
    sess_peer = ($urandom_range(9, 0) == 0) ? 16'($urandom_range(65535, 0))
                                            : 16'($urandom_range(65535, 64));
    send_event(OP_INBOUND_CONN, 1'($urandom_range(1, 0)), 16'($urandom_range(65535, 0)),
               sess_peer, 16'($urandom_range(65535, 0)));
    maybe_noise();
    if ($urandom_range(99, 0) < 60) begin
      send_event(OP_OPEN, 1'($urandom_range(1, 0)), 16'($urandom_range(65535, 0)),
                 16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)));
    end
    if ($urandom_range(99, 0) < 30) begin
      send_event(OP_CFG_RSP, 1'b0, cur_own, 16'($urandom_range(65535, 0)),
                 CFG_RES_PENDING);
    end
    maybe_noise();
    if ($urandom_range(99, 0) < 90) begin
      send_event(OP_CFG_REQ, 1'($urandom_range(1, 0)), cur_own,
                 16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)));
    end
    maybe_noise();
    if ($urandom_range(99, 0) < 90) begin
      send_event(OP_CFG_RSP, 1'b0, cur_own, 16'($urandom_range(65535, 0)),
                 CFG_RES_SUCCESS);
    end else begin
      send_event(OP_CFG_RSP, 1'($urandom_range(1, 0)), cur_own,
                 16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)));
    end
    if ($urandom_range(99, 0) < 20) begin
      send_event(OP_OPEN, 1'b0, cur_own, sess_peer, CONN_RES_SUCCESS);
    end
    maybe_noise();
    close_pick = $urandom_range(99, 0);
    if (close_pick < 45) begin
      send_event(OP_DISC_REQ, 1'($urandom_range(1, 0)), cur_own, sess_peer,
                 16'($urandom_range(65535, 0)));
    end else if (close_pick < 75) begin
      send_event(OP_LOCAL_DISC, 1'($urandom_range(1, 0)), 16'($urandom_range(65535, 0)),
                 16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)));
    end else if (close_pick < 85) begin
      send_event(OP_DISC_REQ, 1'b0, cur_own, sess_peer ^ 16'h0001, CONN_RES_SUCCESS);
    end
  endtask

  initial begin
    int idle_by_phase[4];
    int stall_by_phase[4];
    int next_pause;
    idle_by_phase  = '{0, 47, 0, 36};
    stall_by_phase = '{0, 0, 47, 36};
    sb           = new();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    out_tready   = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    src_idle_pct = 0;
    stall_pct    = 0;
    items_sent   = 0;
    quiet_cycles = 0;
    cur_own      = OWN_CID_RESET;
    sess_peer    = INVALID_CID;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed walk through the outbound setup, failures, teardown and inbound restarts
    send_event(OP_CFG_REQ, 1'b0, cur_own, 16'h0080, CFG_RES_SUCCESS);   // not connected
    send_event(OP_CONN_RSP, 1'b0, cur_own, 16'h0080, CONN_RES_SUCCESS); // nothing requested
    send_event(OP_OPEN, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_event(OP_CONN_RSP, 1'b0, cur_own, 16'h0100, CONN_RES_PENDING);
    send_event(OP_CONN_RSP, 1'b1, cur_own, 16'h0100, CONN_RES_SUCCESS); // command reject
    send_event(OP_OPEN, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_event(OP_CONN_RSP, 1'b0, cur_own, 16'h0100, 16'hFFFF);         // bad result
    send_event(OP_OPEN, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_event(OP_CONN_RSP, 1'b0, 16'hFFFF, 16'h0100, CONN_RES_SUCCESS); // wrong local id
    send_event(OP_OPEN, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_event(OP_CONN_RSP, 1'b0, cur_own, 16'h003F, CONN_RES_SUCCESS); // id below dynamic
    send_event(OP_OPEN, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_event(OP_CONN_RSP, 1'b0, cur_own, 16'hFFFF, CONN_RES_SUCCESS);
    send_event(OP_CFG_REQ, 1'b0, 16'h0041, 16'hFFFF, CFG_RES_SUCCESS);  // wrong channel id
    send_event(OP_CFG_RSP, 1'b0, cur_own, 16'hFFFF, CFG_RES_PENDING);
    send_event(OP_CFG_RSP, 1'b0, cur_own, 16'hFFFF, CFG_RES_SUCCESS);
    send_event(OP_CFG_REQ, 1'b0, cur_own, 16'hFFFF, CFG_RES_SUCCESS);   // channel opens
    send_event(OP_DISC_REQ, 1'b0, cur_own, 16'h1234, 16'h0000);         // wrong remote id
    send_event(OP_DISC_REQ, 1'b0, cur_own, 16'hFFFF, 16'h0000);
    send_event(OP_LOCAL_DISC, 1'b0, 16'h0000, 16'h0000, 16'h0000);      // already closed
    send_event(opcode_t'(3'd7), 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);    // unused code
    send_event(OP_INBOUND_CONN, 1'b0, 16'h0000, INVALID_CID, 16'h0000);
    send_event(OP_LOCAL_DISC, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);      // no remote id
    send_event(OP_INBOUND_CONN, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_event(OP_LOCAL_DISC, 1'b0, 16'h0000, 16'h0000, 16'h0000);

    // Random sessions, one register setting and idling pattern per phase
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          program_reg(REG_OWN_CID, 16'hFFFF);
          program_reg(REG_SERVICE_PSM, 16'h0000);
        end
        1: begin
          program_reg(REG_OWN_CID, 16'($urandom_range(65535, 64)));
          program_reg(REG_SERVICE_PSM, 16'hFFFF);
        end
        2: begin
          program_reg(REG_OWN_CID, FIRST_DYNAMIC_ID);
          program_reg(REG_SERVICE_PSM, 16'($urandom_range(65535, 0)));
        end
        default: begin
          program_reg(REG_OWN_CID, 16'($urandom_range(65535, 64)));
          program_reg(REG_SERVICE_PSM, 16'($urandom_range(65535, 0)));
        end
      endcase
      src_idle_pct = idle_by_phase[ph];
      stall_pct    = stall_by_phase[ph];
      next_pause   = items_sent + PAUSE_EVERY;
      while (items_sent < 25 + (ph + 1) * ITEMS_PER_PHASE) begin
        if ($urandom_range(99, 0) < 85) begin
          run_session();
        end else begin
          send_noise();
        end
        if (items_sent >= next_pause) begin
          drain();
          next_pause = items_sent + PAUSE_EVERY;
        end
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (sb.fails == 0 && sb.pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
